[hdl/jfb_pkg.sv]
// Shared types and constants of the joystick frame builder.
package jfb_pkg;

    localparam int BYTE_W    = 8;
    localparam int SAMPLE_W  = 12;
    localparam int CFG_W     = 32;
    localparam int MAG_W     = 4;
    localparam int DIR_W     = 2;
    localparam int ALARM_W   = 3;
    localparam int IN_DATA_W = 64;
    localparam int POS_W     = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] TAIL_BYTE   = 8'h55;
    localparam logic [BYTE_W-1:0] FRAME_TYPE  = 8'h01;
    localparam logic [BYTE_W-1:0] PAD_BYTE    = 8'h00;

    localparam logic [CFG_W-1:0]    DEVICE_ID_RST = 32'd0;
    localparam logic [SAMPLE_W-1:0] DB_LOW_RST    = 12'd1900;
    localparam logic [SAMPLE_W-1:0] DB_HIGH_RST   = 12'd2150;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_CENTER = 2'd0;
    localparam logic [DIR_W-1:0] UD_LOW     = 2'd2;
    localparam logic [DIR_W-1:0] UD_HIGH    = 2'd1;
    localparam logic [DIR_W-1:0] LR_LOW     = 2'd1;
    localparam logic [DIR_W-1:0] LR_HIGH    = 2'd2;

    typedef enum logic [1:0] {
        CFG_DEVICE_ID = 2'd0,
        CFG_DB_LOW    = 2'd1,
        CFG_DB_HIGH   = 2'd2
    } t_cfg_idx;

    // byte positions within the frame
    localparam logic [POS_W-1:0] POS_HDR0    = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR1    = 5'd1;
    localparam logic [POS_W-1:0] POS_TYPE    = 5'd2;
    localparam logic [POS_W-1:0] POS_ID3     = 5'd3;
    localparam logic [POS_W-1:0] POS_ID2     = 5'd4;
    localparam logic [POS_W-1:0] POS_ID1     = 5'd5;
    localparam logic [POS_W-1:0] POS_ID0     = 5'd6;
    localparam logic [POS_W-1:0] POS_UD_DIR  = 5'd7;
    localparam logic [POS_W-1:0] POS_UD_MAG  = 5'd8;
    localparam logic [POS_W-1:0] POS_LR_DIR  = 5'd9;
    localparam logic [POS_W-1:0] POS_LR_MAG  = 5'd10;
    localparam logic [POS_W-1:0] POS_ALARM   = 5'd11;
    localparam logic [POS_W-1:0] POS_LED1    = 5'd12;
    localparam logic [POS_W-1:0] POS_LED2    = 5'd13;
    localparam logic [POS_W-1:0] POS_WHISTLE = 5'd14;
    localparam logic [POS_W-1:0] POS_BACKUP  = 5'd15;
    localparam logic [POS_W-1:0] POS_PAD     = 5'd16;
    localparam logic [POS_W-1:0] POS_CSUM    = 5'd17;
    localparam logic [POS_W-1:0] POS_TAIL0   = 5'd18;
    localparam logic [POS_W-1:0] POS_TAIL1   = 5'd19;

    typedef struct packed {
        logic [CFG_W-1:0]    device_id;
        logic [SAMPLE_W-1:0] db_low;
        logic [SAMPLE_W-1:0] db_high;
    } t_cfg;

    typedef struct packed {
        logic [DIR_W-1:0] code;
        logic [MAG_W-1:0] mag;
    } t_axis;

    typedef struct packed {
        t_axis               ud;
        t_axis               lr;
        logic [ALARM_W-1:0]  alarm;
        logic [BYTE_W-1:0]   led_one;
        logic [BYTE_W-1:0]   led_two;
        logic [BYTE_W-1:0]   whistle;
        logic [BYTE_W-1:0]   backup;
    } t_job;

endpackage

[hdl/jfb_front.sv]
// Front end: takes a sample word, classifies both axes, holds the result for the queue.
module jfb_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  jfb_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [jfb_pkg::IN_DATA_W-1:0] i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output jfb_pkg::t_job                o_job
);

    function automatic jfb_pkg::t_axis classify(
        input logic [jfb_pkg::SAMPLE_W-1:0] v,
        input logic [jfb_pkg::SAMPLE_W-1:0] lo,
        input logic [jfb_pkg::SAMPLE_W-1:0] hi,
        input logic [jfb_pkg::DIR_W-1:0]    lo_code,
        input logic [jfb_pkg::DIR_W-1:0]    hi_code
    );
        jfb_pkg::t_axis                a;
        logic [jfb_pkg::SAMPLE_W-1:0]  d;
        d = '0;
        if (v < lo) begin
            d      = lo - v;
            a.code = lo_code;
            a.mag  = d[jfb_pkg::SAMPLE_W-1 -: jfb_pkg::MAG_W];
        end else if (v > hi) begin
            d      = v - hi;
            a.code = hi_code;
            a.mag  = d[jfb_pkg::SAMPLE_W-1 -: jfb_pkg::MAG_W];
        end else begin
            a.code = jfb_pkg::DIR_CENTER;
            a.mag  = '0;
        end
        return a;
    endfunction

    logic          r_valid;
    jfb_pkg::t_job r_job;
    jfb_pkg::t_job n_job;
    logic          w_take;

    logic [jfb_pkg::SAMPLE_W-1:0] w_ud;
    logic [jfb_pkg::SAMPLE_W-1:0] w_lr;

    assign o_ready = !r_valid || i_ready;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    assign w_ud = i_data[11:0];
    assign w_lr = ~i_data[23:12];   // 4095 - reading

    always_comb begin
        n_job.ud      = classify(w_ud, i_cfg.db_low, i_cfg.db_high,
                                 jfb_pkg::UD_LOW, jfb_pkg::UD_HIGH);
        n_job.lr      = classify(w_lr, i_cfg.db_low, i_cfg.db_high,
                                 jfb_pkg::LR_LOW, jfb_pkg::LR_HIGH);
        n_job.alarm   = i_data[26:24];
        n_job.led_one = i_data[34:27];
        n_job.led_two = i_data[42:35];
        n_job.whistle = i_data[50:43];
        n_job.backup  = i_data[58:51];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (w_take) begin
            r_job <= n_job;
        end
    end

endmodule

[hdl/jfb_queue.sv]
// Short job queue between the front end and the frame serializer.
module jfb_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jfb_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output jfb_pkg::t_job o_job,
    input  logic          i_pop
);

    localparam logic [jfb_pkg::Q_AW-1:0] LAST_SLOT = jfb_pkg::Q_AW'(jfb_pkg::QUEUE_DEPTH - 1);
    localparam logic [jfb_pkg::Q_AW:0]   FULL_CNT  = (jfb_pkg::Q_AW+1)'(jfb_pkg::QUEUE_DEPTH);

    jfb_pkg::t_job               r_mem [jfb_pkg::QUEUE_DEPTH];
    logic [jfb_pkg::Q_AW-1:0]    r_wr_ptr;
    logic [jfb_pkg::Q_AW-1:0]    r_rd_ptr;
    logic [jfb_pkg::Q_AW:0]      r_count;
    logic                        w_push;
    logic                        w_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[hdl/jfb_back.sv]
// Back end: walks the 20 frame positions of the head job, one byte per word, with running checksum.
module jfb_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  jfb_pkg::t_cfg             i_cfg,
    input  logic                      i_valid,
    input  jfb_pkg::t_job             i_job,
    output logic                      o_pop,
    output logic                      o_tvalid,
    input  logic                      i_tready,
    output logic [jfb_pkg::BYTE_W-1:0] o_tdata,
    output logic                      o_tlast
);

    logic                        r_out_valid;
    logic [jfb_pkg::BYTE_W-1:0]  r_out_byte;
    logic                        r_out_last;
    logic [jfb_pkg::POS_W-1:0]   r_pos;
    logic [jfb_pkg::BYTE_W-1:0]  r_sum;
    logic [jfb_pkg::BYTE_W-1:0]  n_byte;
    logic [jfb_pkg::BYTE_W-1:0]  n_sum;
    logic                        w_adv;
    logic                        w_emit;
    logic                        w_end;

    assign w_adv    = !r_out_valid || i_tready;
    assign w_emit   = w_adv && i_valid;
    assign w_end    = (r_pos == jfb_pkg::POS_TAIL1);
    assign o_pop    = w_emit && w_end;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_byte;
    assign o_tlast  = r_out_last;

    always_comb begin
        unique case (r_pos)
            jfb_pkg::POS_HDR0,
            jfb_pkg::POS_HDR1:    n_byte = jfb_pkg::HEADER_BYTE;
            jfb_pkg::POS_TYPE:    n_byte = jfb_pkg::FRAME_TYPE;
            jfb_pkg::POS_ID3:     n_byte = i_cfg.device_id[31:24];
            jfb_pkg::POS_ID2:     n_byte = i_cfg.device_id[23:16];
            jfb_pkg::POS_ID1:     n_byte = i_cfg.device_id[15:8];
            jfb_pkg::POS_ID0:     n_byte = i_cfg.device_id[7:0];
            jfb_pkg::POS_UD_DIR:  n_byte = jfb_pkg::BYTE_W'(i_job.ud.code);
            jfb_pkg::POS_UD_MAG:  n_byte = jfb_pkg::BYTE_W'(i_job.ud.mag);
            jfb_pkg::POS_LR_DIR:  n_byte = jfb_pkg::BYTE_W'(i_job.lr.code);
            jfb_pkg::POS_LR_MAG:  n_byte = jfb_pkg::BYTE_W'(i_job.lr.mag);
            jfb_pkg::POS_ALARM:   n_byte = jfb_pkg::BYTE_W'(i_job.alarm);
            jfb_pkg::POS_LED1:    n_byte = i_job.led_one;
            jfb_pkg::POS_LED2:    n_byte = i_job.led_two;
            jfb_pkg::POS_WHISTLE: n_byte = i_job.whistle;
            jfb_pkg::POS_BACKUP:  n_byte = i_job.backup;
            jfb_pkg::POS_CSUM:    n_byte = r_sum;
            jfb_pkg::POS_TAIL0,
            jfb_pkg::POS_TAIL1:   n_byte = jfb_pkg::TAIL_BYTE;
            default:              n_byte = jfb_pkg::PAD_BYTE;
        endcase
    end

    // checksum covers the type byte through the backup byte
    always_comb begin
        if (r_pos == jfb_pkg::POS_HDR0) begin
            n_sum = '0;
        end else if (r_pos >= jfb_pkg::POS_TYPE && r_pos <= jfb_pkg::POS_BACKUP) begin
            n_sum = r_sum + n_byte;
        end else begin
            n_sum = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= jfb_pkg::POS_HDR0;
            r_sum       <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= i_valid;
            end
            if (w_emit) begin
                r_pos <= w_end ? jfb_pkg::POS_HDR0 : r_pos + 1'b1;
                r_sum <= n_sum;
            end
        end
        if (w_emit) begin
            r_out_byte <= n_byte;
            r_out_last <= w_end;
        end
    end

endmodule

[hdl/joystick_frame_builder.sv]
// Top level of the joystick frame builder: config registers, front end, queue, serializer.
//
//  channel   dir  handshake              payload
//  s (in)    in   i_s_tvalid/o_s_tready  i_s_tdata: one control sample
//  m (out)   out  o_m_tvalid/i_m_tready  o_m_tdata: frame byte, o_m_tlast: last byte
//  cfg       in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// Each sample yields 20 bytes, one per cycle from the serializer in the back end while
// i_m_tready is high. A sample is held in the front register, then in a queue slot.
// The front register and the spare queue slot let up to two samples wait behind a frame.
// Synchronous reset restores the register defaults and empties every stage.
// A stall on the output holds the current byte; the input keeps accepting until full.
module joystick_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [11:0] updown_sample, [23:12] leftright_sample, [24] fire_pressed,
    // [25] terror_pressed, [26] ambulance_pressed, [34:27] led_one_state,
    // [42:35] led_two_state, [50:43] whistle_value, [58:51] backup_value, [63:59] zero
    input  logic [63:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [7:0] frame_byte
    output logic [7:0]  o_m_tdata,
    output logic        o_m_tlast,   // last_byte
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    jfb_pkg::t_cfg r_cfg;
    jfb_pkg::t_job w_f_job;
    jfb_pkg::t_job w_q_job;
    logic          w_f_valid;
    logic          w_q_full;
    logic          w_q_valid;
    logic          w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_id <= jfb_pkg::DEVICE_ID_RST;
            r_cfg.db_low    <= jfb_pkg::DB_LOW_RST;
            r_cfg.db_high   <= jfb_pkg::DB_HIGH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == jfb_pkg::CFG_DEVICE_ID) begin
                r_cfg.device_id <= i_cfg_data;
            end else if (i_cfg_idx == jfb_pkg::CFG_DB_LOW) begin
                r_cfg.db_low <= i_cfg_data[jfb_pkg::SAMPLE_W-1:0];
            end else if (i_cfg_idx == jfb_pkg::CFG_DB_HIGH) begin
                r_cfg.db_high <= i_cfg_data[jfb_pkg::SAMPLE_W-1:0];
            end
        end
    end

    jfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .o_valid (w_f_valid),
        .i_ready (!w_q_full),
        .o_job   (w_f_job)
    );

    jfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_job   (w_f_job),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .i_pop   (w_q_pop)
    );

    jfb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (w_q_valid),
        .i_job    (w_q_job),
        .o_pop    (w_q_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tlast  (o_m_tlast)
    );

    // a new frame always opens with the header byte
    a_hdr_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=>
            (!o_m_tvalid || o_m_tdata == jfb_pkg::HEADER_BYTE))
        else $error("frame does not start with header");

    a_last_is_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata == jfb_pkg::TAIL_BYTE))
        else $error("last byte is not tail");

    // queue pops only while it holds a job
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("pop from empty queue");

    // a full queue with a waiting front register back-pressures the input
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_f_valid && w_q_full) |-> !o_s_tready)
        else $error("input accepted while front is blocked");

endmodule
